/* design/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mfba_pkg.sv */
package mfba_pkg;

  localparam int unsigned FLOW_W = 21;
  localparam int unsigned NODE_W = 5;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_SINK       = 2'd2;

  // Controller to datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,       // write zero at clear address, advance
    CMD_LOAD,        // write one capacity entry
    CMD_START,       // clear flow total, check terminals
    CMD_BFS_INIT,    // reset visited, queue source
    CMD_BFS_POP,     // take queue head
    CMD_BFS_SCAN,    // issue read of (v,k)
    CMD_BFS_CHECK,   // evaluate read data for k
    CMD_BN_READ,     // read forward entry on chain
    CMD_BN_CHECK,    // fold into bottleneck
    CMD_AUG_READF,   // read forward entry
    CMD_AUG_WRITEF,  // write forward entry, read backward
    CMD_AUG_WRITEB,  // write backward entry, step chain
    CMD_FLOW_ADD     // accumulate bottleneck
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bad_terms;
    logic queue_empty;
    logic scan_last;
    logic found;
    logic chain_done;
    logic last_edge;
  } dp_status_t;

endpackage

/* design/mfba_datapath.sv */
`include "assert_macros.svh"
module mfba_datapath #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned CAP_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfba_pkg::cmd_t                cmd,
  input  logic [4:0]                    ld_from,
  input  logic [4:0]                    ld_to,
  input  logic [15:0]                   ld_cap,
  input  logic [5:0]                    node_count,
  input  logic [4:0]                    source_node,
  input  logic [4:0]                    sink_node,
  output mfba_pkg::dp_status_t          status,
  output logic [mfba_pkg::FLOW_W-1:0]   flow_total
);
  import mfba_pkg::*;

  localparam int unsigned IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned RW    = CAP_BITS + 1;
  localparam int unsigned SW    = ((RW > FLOW_W) ? RW : FLOW_W) + 1;
  localparam logic [RW-1:0] RES_MAX = {RW{1'b1}};

  // Residual matrix memory, one write port and one read port, registered read.
  logic [RW-1:0] mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [IW-1:0] pred_r [MAX_NODES];
  logic [IW-1:0] queue_r [MAX_NODES];
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [IW-1:0] v_r, v_nxt, k_r, k_nxt, cur_r, cur_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [RW-1:0] bn_r, bn_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          clr_done_r, clr_done_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] n_eff;
  logic [IW-1:0] src, dst, p;
  logic          pred_we, queue_we;
  logic [IW-1:0] pred_idx, pred_val, queue_idx, queue_val;
  logic [RW:0]   back_sum;
  logic [SW-1:0] flow_sum;
  logic [RW-1:0] ld_val;
  logic          ld_ok;

  assign n_eff = ({1'b0, node_count} > (7)'(MAX_NODES)) ? (CW)'(MAX_NODES)
                                                           : (CW)'(node_count);
  assign src = (IW)'(source_node);
  assign dst = (IW)'(sink_node);
  assign p   = pred_r[cur_r];
  assign back_sum = {1'b0, rdata_r} + {1'b0, bn_r};
  assign flow_sum = (SW)'(flow_r) + (SW)'(bn_r);
  assign ld_val = (RW)'(ld_cap & 16'((64'd1 << CAP_BITS) - 64'd1));
  assign ld_ok = ({27'd0, ld_from} < 32'(MAX_NODES)) && ({27'd0, ld_to} < 32'(MAX_NODES));

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = {v_r, k_r};
    visited_nxt = visited_r; head_nxt = head_r; tail_nxt = tail_r;
    v_nxt = v_r; k_nxt = k_r; cur_nxt = cur_r; scan_nxt = scan_r;
    bn_nxt = bn_r; clr_nxt = clr_r; clr_done_nxt = clr_done_r;
    flow_nxt = flow_r; found_nxt = found_r;
    pred_we = 1'b0; pred_idx = k_r; pred_val = v_r;
    queue_we = 1'b0; queue_idx = tail_r[IW-1:0]; queue_val = k_r;
    case (cmd)
      CMD_CLEAR: begin
        we = 1'b1; waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW)'(DEPTH - 1)) clr_done_nxt = 1'b1;
      end
      CMD_LOAD: begin
        we = ld_ok; waddr = {(IW)'(ld_from), (IW)'(ld_to)}; wdata = ld_val;
      end
      CMD_START: flow_nxt = '0;
      CMD_BFS_INIT: begin
        visited_nxt = '0; visited_nxt[src] = 1'b1;
        queue_we = 1'b1; queue_idx = '0; queue_val = src;
        head_nxt = '0; tail_nxt = (CW)'(1); found_nxt = 1'b0;
      end
      CMD_BFS_POP: begin
        v_nxt = queue_r[head_r[IW-1:0]];
        head_nxt = head_r + 1'b1;
        k_nxt = '0; scan_nxt = '0;
      end
      CMD_BFS_SCAN: raddr = {v_r, k_r};
      CMD_BFS_CHECK: begin
        if (!visited_r[k_r] && rdata_r != '0) begin
          if (tail_r < n_eff) begin
            queue_we = 1'b1; tail_nxt = tail_r + 1'b1;
          end
          visited_nxt[k_r] = 1'b1;
          pred_we = 1'b1;
          if (k_r == dst) found_nxt = 1'b1;
        end
        k_nxt = k_r + 1'b1; scan_nxt = scan_r + 1'b1;
        cur_nxt = dst; bn_nxt = RES_MAX;
      end
      CMD_BN_READ: raddr = {p, cur_r};
      CMD_BN_CHECK: begin
        if (rdata_r < bn_r) bn_nxt = rdata_r;
        cur_nxt = p;
        if (p == src) cur_nxt = dst;
      end
      CMD_AUG_READF: raddr = {p, cur_r};
      CMD_AUG_WRITEF: begin
        we = 1'b1; waddr = {p, cur_r}; wdata = rdata_r - bn_r;
        raddr = {cur_r, p};
      end
      CMD_AUG_WRITEB: begin
        we = 1'b1; waddr = {cur_r, p};
        wdata = back_sum[RW] ? RES_MAX : back_sum[RW-1:0];
        cur_nxt = p;
      end
      CMD_FLOW_ADD: flow_nxt = (flow_sum > (SW)'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0; head_r <= '0; tail_r <= '0; clr_r <= '0;
      clr_done_r <= 1'b0; flow_r <= '0; found_r <= 1'b0;
    end else begin
      visited_r <= visited_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      clr_r <= clr_nxt; clr_done_r <= clr_done_nxt; flow_r <= flow_nxt;
      found_r <= found_nxt;
    end
    v_r <= v_nxt; k_r <= k_nxt; cur_r <= cur_nxt; scan_r <= scan_nxt; bn_r <= bn_nxt;
    if (pred_we) pred_r[pred_idx] <= pred_val;
    if (queue_we) queue_r[queue_idx] <= queue_val;
  end

  assign status.clear_done  = clr_done_r;
  assign status.bad_terms   = ({1'b0, source_node} >= n_eff) || ({1'b0, sink_node} >= n_eff)
                              || (source_node == sink_node);
  assign status.queue_empty = (head_r == tail_r) || (head_r >= n_eff);
  assign status.scan_last   = (scan_r == n_eff - 1'b1);
  assign status.found       = found_r;
  assign status.chain_done  = (cur_r == src);
  assign status.last_edge   = (p == src);
  assign flow_total = flow_r;

  `ASSERT_ALWAYS(a_tail_bound, clk, rst_n, tail_r <= (CW)'(MAX_NODES), "queue tail beyond node limit")
  `ASSERT_NEXT(a_flow_clear, clk, rst_n, cmd == CMD_START, flow_r == '0, "flow total not cleared")
  `ASSERT_ALWAYS(a_head_tail, clk, rst_n, head_r <= tail_r || cmd == CMD_NONE || cmd == CMD_CLEAR || cmd == CMD_LOAD, "queue head passed tail")
endmodule

/* design/mfba_ctrl.sv */
`include "assert_macros.svh"
module mfba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mfba_pkg::dp_status_t status,
  output mfba_pkg::cmd_t       cmd
);
  import mfba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_INIT, S_POP, S_SCAN, S_CHECK,
    S_BN_RD, S_BN_CK, S_AUG_RF, S_AUG_WF, S_AUG_WB, S_ADD, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = CMD_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (status.clear_done) begin
          cmd = CMD_NONE; state_nxt = S_IDLE;
        end
      end
      S_IDLE: if (in_valid) begin
        if (in_op == OP_LOAD) cmd = CMD_LOAD;
        else begin
          cmd = CMD_START; state_nxt = S_START;
        end
      end
      S_START: state_nxt = status.bad_terms ? S_OUT : S_INIT;
      S_INIT: begin cmd = CMD_BFS_INIT; state_nxt = S_POP; end
      S_POP: begin
        if (status.queue_empty) state_nxt = S_OUT;
        else begin cmd = CMD_BFS_POP; state_nxt = S_SCAN; end
      end
      S_SCAN: begin cmd = CMD_BFS_SCAN; state_nxt = S_CHECK; end
      S_CHECK: begin
        cmd = CMD_BFS_CHECK;
        state_nxt = status.scan_last ? S_POP : S_SCAN;
      end
      S_BN_RD: begin cmd = CMD_BN_READ; state_nxt = S_BN_CK; end
      S_BN_CK: begin
        cmd = CMD_BN_CHECK;
        state_nxt = status.last_edge ? S_AUG_RF : S_BN_RD;
      end
      S_AUG_RF: begin cmd = CMD_AUG_READF; state_nxt = S_AUG_WF; end
      S_AUG_WF: begin cmd = CMD_AUG_WRITEF; state_nxt = S_AUG_WB; end
      S_AUG_WB: begin cmd = CMD_AUG_WRITEB; state_nxt = S_AUG_RF; end
      S_ADD: begin cmd = CMD_FLOW_ADD; state_nxt = S_INIT; end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // Path found: leave the scan, then walk the chain twice.
    if (state_r == S_SCAN && status.found) begin
      cmd = CMD_NONE; state_nxt = S_BN_RD;
    end
    if (state_r == S_POP && status.found) begin
      cmd = CMD_NONE; state_nxt = S_BN_RD;
    end
    if (state_r == S_AUG_RF && status.chain_done) begin
      cmd = CMD_NONE; state_nxt = S_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_ALWAYS(a_excl, clk, rst_n, !(in_ready && out_valid), "input taken while result pending")
  `ASSERT_NEXT(a_start, clk, rst_n, in_valid && in_ready && in_op == OP_COMPUTE, state_r == S_START, "compute not started")
endmodule

/* design/max_flow_bfs_augment.sv */
// channel | ports                                     | direction
// in      | in_valid/in_ready, op from_node to_node cap | to block
// out     | out_valid/out_ready, out_max_flow            | from block
// cfg     | cfg_valid/cfg_ready, cfg_index cfg_data      | to block
// Loads are taken in idle and can come back to back. Compute checks the terminals, then each
// BFS round inits, then pops each node and reads/checks each candidate neighbour (cut short at
// the sink); each path found is walked for the bottleneck, then again to update both residuals.
// After reset a clearing pass over 2**(2*clog2(MAX_NODES)) entries (1024 at 32 nodes) holds
// in_ready low. A stalled result blocks new input until taken.
`include "assert_macros.svh"
module max_flow_bfs_augment #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned CAP_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [4:0]  in_from_node,
  input  logic [4:0]  in_to_node,
  input  logic [15:0] in_capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_max_flow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import mfba_pkg::*;

  logic [5:0] node_count_r;
  logic [4:0] source_r, sink_r;
  cmd_t       cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 6'd32; source_r <= 5'd0; sink_r <= 5'd31;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_data;
        CFG_SOURCE:     source_r <= cfg_data[4:0];
        CFG_SINK:       sink_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  mfba_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .out_valid, .out_ready,
    .status, .cmd
  );

  mfba_datapath #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dp (
    .clk, .rst_n, .cmd, .ld_from(in_from_node), .ld_to(in_to_node),
    .ld_cap(in_capacity), .node_count(node_count_r), .source_node(source_r),
    .sink_node(sink_r), .status, .flow_total(out_max_flow)
  );
endmodule

/* bench/tb_max_flow_bfs_augment.sv */
`timescale 1ns / 100ps

module tb_max_flow_bfs_augment;
  import mfba_pkg::*;

  class flow_scoreboard;
    logic [16:0] residual [32][32];
    bit          seen [32];
    logic [4:0]  came_from [32];
    logic [4:0]  frontier [32];
    int unsigned node_cnt;
    int unsigned src_node;
    int unsigned snk_node;
    logic [20:0] expected_flows [$];
    int          mismatches;

    function new();
      foreach (residual[i, j]) residual[i][j] = '0;
      node_cnt   = 32;
      src_node   = 0;
      snk_node   = 31;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] data);
      if (idx == CFG_NODE_COUNT) node_cnt = data;
      else if (idx == CFG_SOURCE) src_node = data[4:0];
      else if (idx == CFG_SINK) snk_node = data[4:0];
    endfunction

    // Breadth-first search over nonzero residual entries, stop at the sink.
    function bit find_route(int n);
      int head;
      int tail;
      int v;
      head = 0;
      tail = 0;
      for (int k = 0; k < n; k++) seen[k] = 0;
      frontier[0] = src_node;
      tail = 1;
      seen[src_node] = 1;
      while (head != tail && head < n) begin
        v = frontier[head];
        head++;
        for (int k = 0; k < n; k++) begin
          if (!seen[k] && residual[v][k] != 0) begin
            if (tail < n) begin
              frontier[tail] = k;
              tail++;
            end
            seen[k] = 1;
            came_from[k] = v;
            if (k == snk_node) return 1;
          end
        end
      end
      return 0;
    endfunction

    function logic [20:0] max_flow();
      int          n;
      int          i;
      int          p;
      logic [16:0] neck;
      logic [17:0] back;
      logic [21:0] total;
      n = (node_cnt > 32) ? 32 : node_cnt;
      total = '0;
      if (src_node >= n || snk_node >= n || src_node == snk_node) return '0;
      while (find_route(n)) begin
        neck = '1;
        for (i = snk_node; i != src_node; i = came_from[i]) begin
          p = came_from[i];
          if (residual[p][i] < neck) neck = residual[p][i];
        end
        for (i = snk_node; i != src_node; i = came_from[i]) begin
          p = came_from[i];
          residual[p][i] = residual[p][i] - neck;
          back = {1'b0, residual[i][p]} + neck;
          residual[i][p] = (back > 18'h1FFFF) ? 17'h1FFFF : back[16:0];
        end
        total = total + neck;
        if (total > 22'h1FFFFF) total = 22'h1FFFFF;
      end
      return total[20:0];
    endfunction

    function void note_input(logic op, logic [4:0] from_n, logic [4:0] to_n,
                             logic [15:0] cap);
      if (op == OP_COMPUTE) expected_flows.push_back(max_flow());
      else residual[from_n][to_n] = {1'b0, cap};
    endfunction

    function void check_result(logic [20:0] got);
      logic [20:0] want;
      bit          bad;
      bad = 0;
      want = 'x;
      if (expected_flows.size() == 0) bad = 1;
      else begin
        want = expected_flows.pop_front();
        bad = (want !== got);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("max_flow mismatch at %0t: expected %0d actual %0d", $realtime, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [4:0]  in_from_node;
  logic [4:0]  in_to_node;
  logic [15:0] in_capacity;
  logic        out_valid;
  logic        out_ready;
  logic [20:0] out_max_flow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  flow_scoreboard sb = new();
  bit  quiet;
  int  stall_left;
  int  items_sent;

  max_flow_bfs_augment i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_from_node (in_from_node),
    .in_to_node   (in_to_node),
    .in_capacity  (in_capacity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_max_flow (out_max_flow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Check result transfers, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_max_flow);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_item(logic op, logic [4:0] from_n, logic [4:0] to_n,
                           logic [15:0] cap);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_from_node <= from_n;
    in_to_node   <= to_n;
    in_capacity  <= cap;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, from_n, to_n, cap);
    items_sent++;
  endtask

  task automatic load(int from_n, int to_n, int cap);
    send_item(OP_LOAD, from_n[4:0], to_n[4:0], cap[15:0]);
  endtask

  task automatic compute();
    send_item(OP_COMPUTE, $urandom, $urandom, $urandom);
  endtask

  // Drop valid and hold until every flow has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_flows.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[5:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data[5:0]);
  endtask

  task automatic set_graph(int n, int src, int snk);
    write_cfg(CFG_NODE_COUNT, n);
    write_cfg(CFG_SOURCE, src);
    write_cfg(CFG_SINK, snk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    int lim;
    int src;
    int snk;
    int edges;
    int cap;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_LOAD;
    in_from_node <= '0;
    in_to_node   <= '0;
    in_capacity  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_NODE_COUNT;
    cfg_data     <= '0;
    stall_left   = 0;
    quiet        = 0;
    items_sent   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes under the reset settings, then degenerate terminals.
    load(0, 31, 65535);
    load(0, 1, 5);
    load(1, 31, 7);
    load(31, 31, 65535);
    load(31, 0, 0);
    load(5, 6, 0);
    compute();
    compute();
    wait_idle();
    set_graph(32, 31, 0);
    compute();
    wait_idle();
    set_graph(32, 0, 0);
    compute();
    wait_idle();
    set_graph(2, 0, 1);
    load(0, 1, 1);
    load(1, 0, 65535);
    compute();
    wait_idle();
    set_graph(2, 1, 0);
    compute();
    wait_idle();
    set_graph(4, 5, 1);
    compute();
    wait_idle();
    set_graph(63, 0, 31);
    load(0, 2, 65535);
    load(2, 31, 65535);
    compute();
    wait_idle();
    set_graph(4, 0, 3);
    load(0, 3, 100);
    compute();

    while (items_sent < 1050) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: n = 32;
        1: n = $urandom_range(33, 63);
        2: n = 2;
        default: n = $urandom_range(3, 8);
      endcase
      lim = (n > 32) ? 32 : n;
      src = $urandom_range(0, lim - 1);
      snk = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 9) == 0) snk = $urandom_range(0, 31);
      else if (snk == src) snk = (src + 1) % lim;
      set_graph(n, src, snk);
      repeat ((lim > 8) ? 2 : $urandom_range(3, 10)) begin
        edges = $urandom_range(1, 8);
        repeat (edges) begin
          case ($urandom_range(0, 9))
            0: cap = 0;
            1, 2: cap = $urandom_range(0, 65535);
            default: cap = $urandom_range(1, 300);
          endcase
          if ($urandom_range(0, 7) == 0)
            load($urandom_range(0, 31), $urandom_range(0, 31), cap);
          else
            load($urandom_range(0, lim - 1), $urandom_range(0, lim - 1), cap);
        end
        if ($urandom_range(0, 4) == 0) compute();
        compute();
      end
    end

    quiet = 0;
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_flows.size() != 0);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_flows.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
